// ===== sv/u8cft_pkg.sv =====
`timescale 1ns / 1ps
// shared types, sizes and helpers for the utf-8 character frequency table
// no dependencies; imported by every module of the block
package u8cft_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int COUNT_BITS    = 32;

  localparam int BYTES_W = 32;
  localparam int LEN_W   = 3;
  localparam int KEY_W   = BYTES_W + LEN_W;
  localparam int USED_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int RANK_W  = 8;
  localparam int CMP_W   = (USED_W > RANK_W) ? USED_W : RANK_W;
  localparam int DIST_W  = 9;
  localparam int ECNT_W  = 32;

  typedef enum logic [1:0] {
    CMD_DATA  = 2'd0,
    CMD_FLUSH = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef logic [KEY_W-1:0]      key_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  // broadcast from the control side to every cell
  typedef struct packed {
    key_t key;
    logic cnt_en;   // a finished character is looked up this cycle
    logic ins_en;   // not found and room left: open a slot and insert
  } cell_op_t;

  function automatic logic [LEN_W-1:0] lead_length(input logic [7:0] b);
    logic [LEN_W-1:0] len;
    if ((b & 8'hE0) == 8'hC0) len = LEN_W'(2);
    else if ((b & 8'hF0) == 8'hE0) len = LEN_W'(3);
    else if ((b & 8'hF8) == 8'hF0) len = LEN_W'(4);
    else len = LEN_W'(1);
    return len;
  endfunction

  function automatic logic [ECNT_W-1:0] clamp_count(input count_t c);
    logic [63:0] w;
    logic [ECNT_W-1:0] res;
    w = 64'(c);
    if (w > 64'h0000_0000_FFFF_FFFF) res = '1;
    else res = w[ECNT_W-1:0];
    return res;
  endfunction

endpackage

// ===== sv/u8cft_asm.sv =====
`timescale 1ns / 1ps
// character assembler: gathers stream bytes into one utf-8 character key
// depends on u8cft_pkg
module u8cft_asm
  import u8cft_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       req,       // input request accepted this cycle
  input  cmd_t       cmd,
  input  logic [7:0] data_byte,
  output logic       cnt_en,    // a character is finished this cycle
  output key_t       key
);

  logic [BYTES_W-1:0] bytes_r, bytes_nxt, bytes_add;
  logic [LEN_W-1:0]   len_r, len_nxt, len_add;
  logic [LEN_W-1:0]   exp_r, exp_nxt, exp_add;
  logic [4:0]         sh;

  always_comb begin
    sh        = 5'd24 - 5'({len_r, 3'b000});
    bytes_add = '0;
    len_add   = len_r;
    exp_add   = exp_r;
    if (len_r == '0) begin
      exp_add   = lead_length(data_byte);
      bytes_add = {data_byte, 24'h0};
      len_add   = LEN_W'(1);
    end else begin
      bytes_add = bytes_r | (BYTES_W'(data_byte) << sh);
      len_add   = len_r + LEN_W'(1);
    end

    cnt_en    = 1'b0;
    key       = {bytes_r, len_r};
    bytes_nxt = bytes_r;
    len_nxt   = len_r;
    exp_nxt   = exp_r;
    if (req) begin
      case (cmd)
        CMD_DATA: begin
          key = {bytes_add, len_add};
          if (len_add >= exp_add) begin
            cnt_en    = 1'b1;
            bytes_nxt = '0;
            len_nxt   = '0;
            exp_nxt   = '0;
          end else begin
            bytes_nxt = bytes_add;
            len_nxt   = len_add;
            exp_nxt   = exp_add;
          end
        end
        CMD_FLUSH: begin
          if (len_r != '0) begin
            cnt_en    = 1'b1;
            bytes_nxt = '0;
            len_nxt   = '0;
            exp_nxt   = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_r <= '0;
      len_r   <= '0;
      exp_r   <= '0;
    end else begin
      bytes_r <= bytes_nxt;
      len_r   <= len_nxt;
      exp_r   <= exp_nxt;
    end
  end

endmodule

// ===== sv/u8cft_cell.sv =====
`timescale 1ns / 1ps
// one table cell: holds a key and its count, compares against the broadcast key
// and takes its lower neighbor's entry when a slot opens below it; uses u8cft_pkg
module u8cft_cell
  import u8cft_pkg::*;
(
  input  logic     clk,
  input  logic     vld,        // this cell lies below the fill level
  input  cell_op_t op,
  input  logic     prev_lt,    // lower neighbor sorts before the new key
  input  key_t     prev_key,
  input  count_t   prev_count,
  output logic     lt,
  output logic     match,
  output key_t     key,
  output count_t   count
);

  key_t   key_r;
  count_t count_r;

  assign lt    = vld && (key_r < op.key);
  assign match = vld && (key_r == op.key);
  assign key   = key_r;
  assign count = count_r;

  always_ff @(posedge clk) begin
    if (op.cnt_en && match) begin
      if (count_r != '1) count_r <= count_r + COUNT_BITS'(1);
    end else if (op.ins_en && !lt) begin
      if (prev_lt) begin
        key_r   <= op.key;
        count_r <= COUNT_BITS'(1);
      end else begin
        key_r   <= prev_key;
        count_r <= prev_count;
      end
    end
  end

endmodule

// ===== sv/utf8_char_frequency_table.sv =====
`timescale 1ns / 1ps
// top level of the utf-8 character frequency table: assembler, row of sorted cells,
// fill counter, rank read and output register; depends on u8cft_pkg, u8cft_asm, u8cft_cell
//
//  channel  | ports                    | payload
//  ---------+--------------------------+-----------------------------------------------
//  input    | in_tvalid/tready/tdata/  | tdata: data_byte, rank; tuser: cmd
//           | in_tuser                 |
//  result   | out_tvalid/tready/tdata  | char_done, table_full, entry_valid,
//           |                          | entry_bytes, entry_length, entry_count,
//           |                          | distinct_count
//
// all cells compare the new key at once and bump the matching count, shift up by one
// to open the sorted slot, or drop the character when the table is full; one character is
// counted per clock while in_tready is high; a read picks the ranked cell that same cycle.
// one result per request sits in the output register; a new request is taken while
// that register is empty or being drained, otherwise in_tready drops.
// synchronous reset empties the table (fill level zero) and the character assembler;
// no clearing pass is needed.
module utf8_char_frequency_table
  import u8cft_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] data_byte, [15:8] rank
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata   // [0] char_done, [1] table_full, [2] entry_valid,
                                  // [34:3] entry_bytes, [37:35] entry_length,
                                  // [69:38] entry_count, [78:70] distinct_count, [79] 0
);

  logic               req;
  cmd_t               cmd;
  logic [7:0]         data_byte;
  logic [RANK_W-1:0]  rank;
  logic               cnt_en;
  key_t               new_key;
  cell_op_t           op;

  logic [USED_W-1:0]  used_r, used_nxt;
  logic               full;
  logic               any_match;

  logic [TABLE_ENTRIES-1:0] cell_vld, cell_lt, cell_match;
  key_t                     cell_key   [TABLE_ENTRIES];
  count_t                   cell_count [TABLE_ENTRIES];

  logic               rd_hit;
  key_t               rd_key;
  count_t             rd_count;

  logic               out_vld_r;
  logic [79:0]        out_data_r, out_data_nxt;

  assign in_tready = !out_vld_r || out_tready;
  assign req       = in_tvalid && in_tready;
  assign cmd       = cmd_t'(in_tuser);
  assign data_byte = in_tdata[7:0];
  assign rank      = in_tdata[15:8];

  u8cft_asm u_asm (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .cmd       (cmd),
    .data_byte (data_byte),
    .cnt_en    (cnt_en),
    .key       (new_key)
  );

  assign full      = (32'(used_r) == TABLE_ENTRIES);
  assign any_match = |cell_match;

  always_comb begin
    op.key    = new_key;
    op.cnt_en = cnt_en;
    op.ins_en = cnt_en && !any_match && !full;
  end

  genvar g;
  generate
    for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      assign cell_vld[g] = (32'(used_r) > g);
      if (g == 0) begin : g_first
        u8cft_cell u_cell (
          .clk        (clk),
          .vld        (cell_vld[g]),
          .op         (op),
          .prev_lt    (1'b1),
          .prev_key   ('0),
          .prev_count ('0),
          .lt         (cell_lt[g]),
          .match      (cell_match[g]),
          .key        (cell_key[g]),
          .count      (cell_count[g])
        );
      end else begin : g_rest
        u8cft_cell u_cell (
          .clk        (clk),
          .vld        (cell_vld[g]),
          .op         (op),
          .prev_lt    (cell_lt[g-1]),
          .prev_key   (cell_key[g-1]),
          .prev_count (cell_count[g-1]),
          .lt         (cell_lt[g]),
          .match      (cell_match[g]),
          .key        (cell_key[g]),
          .count      (cell_count[g])
        );
      end
    end
  endgenerate

  // rank select: one-hot over the cells, or-combined
  always_comb begin
    rd_hit   = (CMP_W'(rank) < CMP_W'(used_r));
    rd_key   = '0;
    rd_count = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (CMP_W'(rank) == CMP_W'(i)) begin
        rd_key   = rd_key | cell_key[i];
        rd_count = rd_count | cell_count[i];
      end
    end
  end

  always_comb begin
    used_nxt = used_r;
    if (req && cmd == CMD_CLEAR) used_nxt = '0;
    else if (op.ins_en) used_nxt = used_r + USED_W'(1);

    out_data_nxt = '0;
    out_data_nxt[0] = cnt_en && (any_match || !full);
    out_data_nxt[1] = cnt_en && !any_match && full;
    if (cmd == CMD_READ && rd_hit) begin
      out_data_nxt[2]     = 1'b1;
      out_data_nxt[34:3]  = rd_key[KEY_W-1:LEN_W];
      out_data_nxt[37:35] = rd_key[LEN_W-1:0];
      out_data_nxt[69:38] = clamp_count(rd_count);
    end
    out_data_nxt[78:70] = DIST_W'(used_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      used_r <= used_nxt;
      if (req) out_vld_r <= 1'b1;
      else if (out_tready) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req) out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== sim/utf8_char_frequency_table_test.sv =====
`timescale 1ns / 1ps
// self-checking bench for utf8_char_frequency_table: random and directed byte streams,
// a sorted histogram predictor and an in-order result checker; depends on u8cft_pkg
module utf8_char_frequency_table_test
  import u8cft_pkg::*;
;

  typedef struct {
    cmd_t       cmd;
    logic [7:0] data_byte;
    logic [7:0] rank;
  } request_t;

  // packed so that it lines up with out_tdata[78:0], last field in the lowest bits
  typedef struct packed {
    logic [8:0]  distinct_count;
    logic [31:0] entry_count;
    logic [2:0]  entry_length;
    logic [31:0] entry_bytes;
    logic        entry_valid;
    logic        table_full;
    logic        char_done;
  } tally_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;

  utf8_char_frequency_table u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // histogram state as the block should hold it
  key_t        char_key [TABLE_ENTRIES];
  count_t      char_cnt [TABLE_ENTRIES];
  int          fill = 0;
  logic [31:0] asm_bytes = '0;
  logic [2:0]  asm_len = '0;
  logic [2:0]  asm_need = '0;

  request_t    req_queue[$];
  tally_t      pend_results[$];
  request_t    nxt;
  logic        in_fire = 1'b0;
  logic        hold_off = 1'b0;
  logic        steady;
  int          n_sent = 0;
  int          n_results = 0;
  int          n_errors = 0;
  int          n_counted = 0;
  int          n_dropped = 0;
  int          n_hits = 0;
  int          peak_fill = 0;

  assign steady = (n_sent >= 700 && n_sent < 900);

  function automatic logic [2:0] char_len(logic [7:0] b);
    casez (b)
      8'b110?????: return 3'd2;
      8'b1110????: return 3'd3;
      8'b11110???: return 3'd4;
      default:     return 3'd1;
    endcase
  endfunction

  // close the character under assembly: bump, insert in order, or drop when full
  function automatic void commit_char(inout tally_t r);
    key_t k;
    int   pos;
    k = {asm_bytes, asm_len};
    pos = 0;
    while (pos < fill && char_key[pos] < k) pos++;
    if (pos < fill && char_key[pos] == k) begin
      if (char_cnt[pos] != '1) char_cnt[pos]++;
      r.char_done = 1'b1;
    end else if (fill >= TABLE_ENTRIES) begin
      r.table_full = 1'b1;
    end else begin
      for (int i = fill; i > pos; i--) begin
        char_key[i] = char_key[i-1];
        char_cnt[i] = char_cnt[i-1];
      end
      char_key[pos] = k;
      char_cnt[pos] = 1;
      fill++;
      r.char_done = 1'b1;
    end
    asm_bytes = '0;
    asm_len = '0;
    asm_need = '0;
  endfunction

  function automatic tally_t tally_request(request_t q);
    tally_t r;
    r = '0;
    case (q.cmd)
      CMD_DATA: begin
        if (asm_len == 0) begin
          asm_need = char_len(q.data_byte);
          asm_bytes = {q.data_byte, 24'h0};
          asm_len = 3'd1;
        end else begin
          asm_bytes = asm_bytes | (32'(q.data_byte) << (24 - 8 * int'(asm_len)));
          asm_len++;
        end
        if (asm_len >= asm_need) commit_char(r);
      end
      CMD_FLUSH: begin
        if (asm_len != 0) commit_char(r);
      end
      CMD_READ: begin
        if (int'(q.rank) < fill) begin
          r.entry_valid = 1'b1;
          r.entry_bytes = char_key[q.rank][34:3];
          r.entry_length = char_key[q.rank][2:0];
          r.entry_count = 32'(char_cnt[q.rank]);
        end
      end
      default: fill = 0;
    endcase
    r.distinct_count = 9'(fill);
    n_counted += r.char_done;
    n_dropped += r.table_full;
    n_hits += r.entry_valid;
    if (fill > peak_fill) peak_fill = fill;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (n_errors < 30)
      $display("mismatch at result %0d: %s got %0h want %0h", n_results, what, got, want);
    n_errors++;
  endtask

  // fields the command does not use are filled with noise
  task automatic add_request(cmd_t c, logic [7:0] d, logic [7:0] rk);
    request_t q;
    q.cmd = c;
    q.data_byte = (c == CMD_DATA) ? d : 8'($urandom);
    q.rank = (c == CMD_READ) ? rk : 8'($urandom);
    req_queue = {req_queue, q};
  endtask

  task automatic add_char(logic [31:0] w, int len);
    for (int k = 0; k < len; k++) add_request(CMD_DATA, w[31 - 8*k -: 8], 8'd0);
  endtask

  function automatic logic [31:0] random_char(int len);
    logic [31:0] w;
    w = $urandom;
    case (len)
      1: begin
        while (char_len(w[31:24]) != 3'd1) w[31:24] = 8'($urandom);
      end
      2: w[31:29] = 3'b110;
      3: w[31:28] = 4'b1110;
      default: w[31:27] = 5'b11110;
    endcase
    // mostly proper continuation bytes, sometimes anything
    for (int k = 1; k < len; k++) begin
      if ($urandom_range(0, 9) != 0) w[31 - 8*k -: 2] = 2'b10;
    end
    return w & ~(32'hFFFF_FFFF >> (8 * len));
  endfunction

  task automatic mixed_run(int n_items, int pool_size);
    logic [31:0] pool_w[$];
    int          pool_l[$];
    int          stop, pick, len, k;
    logic [31:0] w;
    for (int i = 0; i < pool_size; i++) begin
      len = $urandom_range(1, 4);
      pool_w = {pool_w, random_char(len)};
      pool_l = {pool_l, len};
    end
    stop = req_queue.size() + n_items;
    while (req_queue.size() < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        if (pool_size > 0 && $urandom_range(0, 3) != 0) begin
          k = $urandom_range(0, pool_size - 1);
          add_char(pool_w[k], pool_l[k]);
        end else begin
          len = $urandom_range(1, 4);
          add_char(random_char(len), len);
        end
      end else if (pick < 75) begin
        add_request(CMD_READ, 8'd0,
                    $urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom));
      end else if (pick < 81) begin
        add_request(CMD_FLUSH, 8'd0, 8'd0);
      end else if (pick < 83) begin
        add_request(CMD_CLEAR, 8'd0, 8'd0);
      end else if (pick < 91) begin
        // truncated character; the next data bytes continue it unless a flush closes it first
        len = $urandom_range(2, 4);
        w = random_char(len);
        add_char(w, $urandom_range(1, len - 1));
      end else begin
        add_request(CMD_DATA, 8'($urandom), 8'd0);
      end
    end
  endtask

  // push well past the table size, revisiting early characters, then read every rank
  task automatic fill_run(int n_chars);
    logic [31:0] seen_w[$];
    int          seen_l[$];
    int          len, k;
    logic [31:0] w;
    add_request(CMD_CLEAR, 8'd0, 8'd0);
    for (int i = 0; i < n_chars; i++) begin
      if (seen_w.size() > 20 && $urandom_range(0, 6) == 0) begin
        k = $urandom_range(0, (seen_w.size() < 200 ? seen_w.size() : 200) - 1);
        add_char(seen_w[k], seen_l[k]);
      end else begin
        len = $urandom_range(2, 3);
        w = random_char(len);
        add_char(w, len);
        seen_w = {seen_w, w};
        seen_l = {seen_l, len};
      end
      if ($urandom_range(0, 9) == 0) add_request(CMD_READ, 8'd0, 8'($urandom));
    end
    for (int rk = 0; rk < 256; rk++) add_request(CMD_READ, 8'd0, 8'(rk));
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (req_queue.size() > 0 && (steady || hold_off || $urandom_range(0, 99) >= 28)) begin
        nxt = req_queue.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {nxt.rank, nxt.data_byte};
        in_tuser <= nxt.cmd;
        n_sent <= n_sent + 1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= !hold_off && (steady || $urandom_range(0, 99) >= 28);
    end
  end

  // long result back-pressure so the output register fills and in_tready drops
  initial begin
    wait (n_sent >= 250);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (120) @(posedge clk);
    hold_off = 1'b0;
  end

  always @(posedge clk) begin
    request_t q;
    tally_t   got;
    tally_t   want;
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        q.cmd = cmd_t'(in_tuser);
        q.data_byte = in_tdata[7:0];
        q.rank = in_tdata[15:8];
        pend_results = {pend_results, tally_request(q)};
      end
      if (out_tvalid && out_tready) begin
        if (pend_results.size() == 0) begin
          report_mismatch("result with no request pending", 32'd0, 32'd0);
        end else begin
          want = pend_results.pop_front();
          got = tally_t'(out_tdata[78:0]);
          if (got.char_done !== want.char_done)
            report_mismatch("char_done", 32'(got.char_done), 32'(want.char_done));
          if (got.table_full !== want.table_full)
            report_mismatch("table_full", 32'(got.table_full), 32'(want.table_full));
          if (got.entry_valid !== want.entry_valid)
            report_mismatch("entry_valid", 32'(got.entry_valid), 32'(want.entry_valid));
          if (got.entry_bytes !== want.entry_bytes)
            report_mismatch("entry_bytes", got.entry_bytes, want.entry_bytes);
          if (got.entry_length !== want.entry_length)
            report_mismatch("entry_length", 32'(got.entry_length), 32'(want.entry_length));
          if (got.entry_count !== want.entry_count)
            report_mismatch("entry_count", got.entry_count, want.entry_count);
          if (got.distinct_count !== want.distinct_count)
            report_mismatch("distinct_count", 32'(got.distinct_count),
                            32'(want.distinct_count));
          if (out_tdata[79] !== 1'b0)
            report_mismatch("pad bit", 32'(out_tdata[79]), 32'd0);
        end
        n_results++;
      end
    end
  end

  initial begin
    // directed: empty reads, idle flush, extreme bytes, every length, prefix order
    add_request(CMD_READ, 8'd0, 8'd0);
    add_request(CMD_FLUSH, 8'd0, 8'd0);
    add_request(CMD_DATA, 8'h00, 8'd0);
    add_request(CMD_DATA, 8'hFF, 8'd0);
    add_request(CMD_DATA, 8'h80, 8'd0);
    add_request(CMD_DATA, 8'hF8, 8'd0);
    add_char(32'hC3A9_0000, 2);
    add_char(32'hE282_AC00, 3);
    add_char(32'hF09F_9880, 4);
    // partial character at flush, a prefix of the euro sign above
    add_char(32'hE282_0000, 2);
    add_request(CMD_FLUSH, 8'd0, 8'd0);
    add_request(CMD_DATA, 8'h00, 8'd0);
    add_request(CMD_READ, 8'd0, 8'd0);
    add_request(CMD_READ, 8'd0, 8'd4);
    add_request(CMD_READ, 8'd0, 8'd255);
    // clear in the middle of a character keeps the pending lead byte
    add_request(CMD_DATA, 8'hC3, 8'd0);
    add_request(CMD_CLEAR, 8'd0, 8'd0);
    add_request(CMD_DATA, 8'hA9, 8'd0);
    add_request(CMD_READ, 8'd0, 8'd0);
    add_request(CMD_READ, 8'd0, 8'd1);

    mixed_run(250, 6);
    fill_run(340);
    mixed_run(200, 40);

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    while (req_queue.size() != 0 || in_tvalid || pend_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (pend_results.size() != 0)
      report_mismatch("results never delivered", 32'(pend_results.size()), 32'd0);

    $display("sent %0d requests, checked %0d results: %0d characters counted, %0d dropped",
             n_sent, n_results, n_counted, n_dropped);
    $display("%0d reads hit a stored entry, table peaked at %0d distinct characters",
             n_hits, peak_fill);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/u8cft_pkg.sv
sv/u8cft_asm.sv
sv/u8cft_cell.sv
sv/utf8_char_frequency_table.sv
sim/utf8_char_frequency_table_test.sv
